// ===== rtl/core/rbf_pkg.sv =====
// Package for the RGB bilateral filter: sizes, codes, sequencer states,
// shared structs and the spatial-offset helper.
// No dependencies.
package rbf_pkg;

  localparam int RADIUS        = 3;
  localparam int MAX_WIDTH     = 1024;
  localparam int RANGE_DEPTH   = 1024;

  localparam int DIAM          = 2 * RADIUS + 1;
  localparam int LINES         = 2 * RADIUS;
  localparam int NWIN          = DIAM * DIAM;
  localparam int CENTER        = RADIUS * DIAM + RADIUS;
  localparam int SPATIAL_DEPTH = 2 * RADIUS * RADIUS + 1;

  localparam int DW       = $clog2(DIAM);
  localparam int LW       = $clog2(LINES);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RANGE_AW = $clog2(RANGE_DEPTH);
  localparam int SIDX_W   = $clog2(SPATIAL_DEPTH);
  localparam int TIDX_W   = 10;
  localparam int ADDR_W   = (TIDX_W > RANGE_AW) ? TIDX_W : RANGE_AW;
  localparam int PIX_W    = 24;
  localparam int WT_W     = 16;
  localparam int DIST_W   = 18;
  localparam int WSUM_W   = $clog2(NWIN) + WT_W;
  localparam int CSUM_W   = WSUM_W + 8;
  localparam int NUM_W    = CSUM_W + 1;

  localparam logic [1:0] MODE_PIXEL        = 2'd0;
  localparam logic [1:0] MODE_LOAD_SPATIAL = 2'd1;
  localparam logic [1:0] MODE_LOAD_RANGE   = 2'd2;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RANGE_SHIFT  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_CALC,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              spat_we;
    logic              rng_we;
    logic [ADDR_W-1:0] addr;
    logic [WT_W-1:0]   data;
  } wload_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [PIX_W-1:0]  px;
    logic [SIDX_W-1:0] sidx;
  } issue_t;

  function automatic logic [SIDX_W-1:0] sq_off(logic [DW-1:0] a);
    logic [DW-1:0] d;
    if (a >= DW'(RADIUS)) d = a - DW'(RADIUS);
    else d = DW'(RADIUS) - a;
    return SIDX_W'(d) * SIDX_W'(d);
  endfunction

endpackage

// ===== rtl/core/rbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbf_mac.sv =====
// Weight unit: spatial table, range table RAM, weight multiply and
// channel accumulators, one window neighbor per cycle.
// Depends on rbf_pkg and rbf_ram.
module rbf_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rbf_pkg::wload_t            wl_i,
  input  rbf_pkg::issue_t            iss_i,
  input  logic [rbf_pkg::PIX_W-1:0]  centre_i,
  input  logic [4:0]                 range_shift_i,
  input  logic                       acc_clr_i,
  output logic [rbf_pkg::WSUM_W-1:0] wsum_o,
  output logic [rbf_pkg::CSUM_W-1:0] csum_o [3],
  output logic                       done_o
);

  logic [rbf_pkg::WT_W-1:0] spat_q [rbf_pkg::SPATIAL_DEPTH];

  logic                        v1_q, l1_q, v2_q, l2_q, v3_q, l3_q, done_q;
  logic [rbf_pkg::DIST_W-1:0]  dist1_q;
  logic [rbf_pkg::SIDX_W-1:0]  sidx1_q;
  logic [rbf_pkg::PIX_W-1:0]   px1_q, px2_q, px3_q;
  logic [rbf_pkg::WT_W-1:0]    ws2_q, w3_q;
  logic [rbf_pkg::WSUM_W-1:0]  wsum_q;
  logic [rbf_pkg::CSUM_W-1:0]  csum_q [3];

  logic [rbf_pkg::DIST_W-1:0]   dist_d, rsh;
  logic [rbf_pkg::RANGE_AW-1:0] ridx;
  logic [rbf_pkg::WT_W-1:0]     wr;
  logic [2*rbf_pkg::WT_W-1:0]   prod;
  logic [7:0]                   ad [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (iss_i.px[16-8*k +: 8] >= centre_i[16-8*k +: 8])
        ad[k] = iss_i.px[16-8*k +: 8] - centre_i[16-8*k +: 8];
      else
        ad[k] = centre_i[16-8*k +: 8] - iss_i.px[16-8*k +: 8];
    end
    dist_d = rbf_pkg::DIST_W'(16'(ad[0]) * 16'(ad[0]))
           + rbf_pkg::DIST_W'(16'(ad[1]) * 16'(ad[1]))
           + rbf_pkg::DIST_W'(16'(ad[2]) * 16'(ad[2]));
  end

  always_comb begin
    rsh = dist1_q >> range_shift_i;
    if (32'(rsh) > rbf_pkg::RANGE_DEPTH - 1)
      ridx = rbf_pkg::RANGE_AW'(rbf_pkg::RANGE_DEPTH - 1);
    else
      ridx = rbf_pkg::RANGE_AW'(rsh);
  end

  rbf_ram #(
    .WIDTH(rbf_pkg::WT_W),
    .DEPTH(rbf_pkg::RANGE_DEPTH)
  ) u_range_ram (
    .clk_i  (clk_i),
    .we_i   (wl_i.rng_we),
    .waddr_i(rbf_pkg::RANGE_AW'(wl_i.addr)),
    .wdata_i(wl_i.data),
    .re_i   (v1_q),
    .raddr_i(ridx),
    .rdata_o(wr)
  );

  assign prod = (2*rbf_pkg::WT_W)'(ws2_q) * (2*rbf_pkg::WT_W)'(wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbf_pkg::SPATIAL_DEPTH; i++) spat_q[i] <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (wl_i.spat_we) spat_q[rbf_pkg::SIDX_W'(wl_i.addr)] <= wl_i.data;
      v1_q   <= iss_i.valid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q && l3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q    <= iss_i.last;
    dist1_q <= dist_d;
    sidx1_q <= iss_i.sidx;
    px1_q   <= iss_i.px;
    l2_q    <= l1_q;
    ws2_q   <= spat_q[sidx1_q];
    px2_q   <= px1_q;
    l3_q    <= l2_q;
    w3_q    <= prod[2*rbf_pkg::WT_W-1:rbf_pkg::WT_W];
    px3_q   <= px2_q;
    if (acc_clr_i) begin
      wsum_q <= '0;
      for (int k = 0; k < 3; k++) csum_q[k] <= '0;
    end else if (v3_q) begin
      wsum_q <= wsum_q + rbf_pkg::WSUM_W'(w3_q);
      for (int k = 0; k < 3; k++)
        csum_q[k] <= csum_q[k] + rbf_pkg::CSUM_W'(w3_q) * rbf_pkg::CSUM_W'(px3_q[16-8*k +: 8]);
    end
  end

  assign wsum_o = wsum_q;
  assign csum_o = csum_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/rbf_divider.sv =====
// Shared restoring divider: rounded channel means, one quotient bit a cycle,
// three channels in turn; zero weight sum gives the centre pixel.
// Depends on rbf_pkg.
module rbf_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rbf_pkg::WSUM_W-1:0] wsum_i,
  input  logic [rbf_pkg::CSUM_W-1:0] csum_i [3],
  input  logic [rbf_pkg::PIX_W-1:0]  centre_i,
  output logic [7:0]                 chan_o [3],
  output logic                       done_o
);

  logic                     busy_q, done_q;
  logic [1:0]               ch_q;
  logic [2:0]               bit_q;
  logic [rbf_pkg::NUM_W-1:0] rem_q, trial, rem_sub;
  logic [7:0]               quo_q;
  logic [7:0]               res_q [3];
  logic [7:0]               quo_d;

  function automatic logic [rbf_pkg::NUM_W-1:0] numer(logic [rbf_pkg::CSUM_W-1:0] s,
                                                     logic [rbf_pkg::WSUM_W-1:0] w);
    return rbf_pkg::NUM_W'({s, 1'b0}) + rbf_pkg::NUM_W'(w);
  endfunction

  always_comb begin
    trial   = rbf_pkg::NUM_W'({wsum_i, 1'b0}) << bit_q;
    rem_sub = rem_q;
    quo_d   = quo_q;
    if (rem_q >= trial) begin
      rem_sub      = rem_q - trial;
      quo_d[bit_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (wsum_i == '0) done_q <= 1'b1;
        else busy_q <= 1'b1;
      end else if (busy_q && bit_q == 3'd0 && ch_q == 2'd2) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ch_q  <= 2'd0;
      bit_q <= 3'd7;
      quo_q <= '0;
      rem_q <= numer(csum_i[0], wsum_i);
      if (wsum_i == '0) begin
        res_q[0] <= centre_i[23:16];
        res_q[1] <= centre_i[15:8];
        res_q[2] <= centre_i[7:0];
      end
    end else if (busy_q) begin
      if (bit_q == 3'd0) begin
        res_q[ch_q] <= quo_d;
        quo_q       <= '0;
        bit_q       <= 3'd7;
        ch_q        <= ch_q + 2'd1;
        rem_q       <= numer(csum_i[(ch_q == 2'd0) ? 1 : 2], wsum_i);
      end else begin
        quo_q <= quo_d;
        rem_q <= rem_sub;
        bit_q <= bit_q - 3'd1;
      end
    end
  end

  assign chan_o = res_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/rgb_bilateral_filter.sv =====
// Top level of the RGB bilateral filter: sequencer, counters, line stores,
// window and output register. Depends on rbf_pkg, rbf_ram, rbf_mac, rbf_divider.
//
// Takes a border-replicated RGB frame in raster order, one pixel word at a
// time, plus load words that fill the spatial and range weight tables.
// After reset a clearing pass over all RANGE_DEPTH addresses zeroes the range
// table; input is not taken meanwhile, configuration writes are. A load word
// is taken in the idle state. A pixel word that does not complete a window
// passes through a line store read, then window shift and line store write.
// A pixel word that completes a window goes through those two steps, then
// one neighbor per cycle through the shared weight and multiply-accumulate
// unit, its four-stage pipeline drain, then the shared divider at one
// quotient bit per cycle for three channels, and the output load. A result
// waits in the output register while the next word is taken.
module rgb_bilateral_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [9:0]  table_index_i,
  input  logic [15:0] weight_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  rbf_pkg::state_e state_q, state_d;

  logic [10:0] frame_width_q;
  logic [15:0] frame_height_q;
  logic [4:0]  range_shift_q;

  logic [rbf_pkg::CW-1:0]       col_cnt_q, col_q, width_m1;
  logic [15:0]                  row_cnt_q, height_m1;
  logic [rbf_pkg::LW-1:0]       slot_cnt_q, slot_q;
  logic [rbf_pkg::RANGE_AW-1:0] clr_q;
  logic [rbf_pkg::DW-1:0]       a_q, b_q;
  logic [rbf_pkg::PIX_W-1:0]    px_q, centre_q;
  logic                         emit_q, frame_end_q;
  logic                         emit, row_end, frame_end, accept, pix_acc, calc_last;

  logic [rbf_pkg::PIX_W-1:0] win_q [rbf_pkg::NWIN];
  logic [rbf_pkg::PIX_W-1:0] win_d [rbf_pkg::NWIN];
  logic [rbf_pkg::PIX_W-1:0] line_rd [rbf_pkg::LINES];

  logic                 line_re, line_we, acc_clr, div_start, div_done, mac_done, out_load;
  rbf_pkg::wload_t      wl;
  rbf_pkg::issue_t      iss;

  logic [rbf_pkg::WSUM_W-1:0] wsum;
  logic [rbf_pkg::CSUM_W-1:0] csum [3];
  logic [7:0]                 chan [3];

  logic       out_valid_q, out_frame_done_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;

  function automatic logic [rbf_pkg::LW-1:0] rot_slot(logic [rbf_pkg::LW-1:0] s, int a);
    logic [rbf_pkg::LW:0] t;
    t = (rbf_pkg::LW+1)'(s) + (rbf_pkg::LW+1)'(a);
    if (t >= (rbf_pkg::LW+1)'(rbf_pkg::LINES)) t = t - (rbf_pkg::LW+1)'(rbf_pkg::LINES);
    return rbf_pkg::LW'(t);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign pix_acc     = accept && (mode_i == rbf_pkg::MODE_PIXEL);
  assign calc_last   = (a_q == rbf_pkg::DW'(rbf_pkg::DIAM - 1)) &&
                       (b_q == rbf_pkg::DW'(rbf_pkg::DIAM - 1));

  always_comb begin
    if (32'(frame_width_q) < rbf_pkg::DIAM)
      width_m1 = rbf_pkg::CW'(rbf_pkg::DIAM - 1);
    else if (32'(frame_width_q) > rbf_pkg::MAX_WIDTH)
      width_m1 = rbf_pkg::CW'(rbf_pkg::MAX_WIDTH - 1);
    else
      width_m1 = rbf_pkg::CW'(frame_width_q - 11'd1);
    if (32'(frame_height_q) < rbf_pkg::DIAM)
      height_m1 = 16'(rbf_pkg::DIAM - 1);
    else
      height_m1 = frame_height_q - 16'd1;
    emit      = (32'(row_cnt_q) >= rbf_pkg::LINES) && (32'(col_cnt_q) >= rbf_pkg::LINES);
    row_end   = col_cnt_q >= width_m1;
    frame_end = row_end && (row_cnt_q >= height_m1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbf_pkg::ST_CLEAR: if (clr_q == rbf_pkg::RANGE_AW'(rbf_pkg::RANGE_DEPTH - 1))
                           state_d = rbf_pkg::ST_IDLE;
      rbf_pkg::ST_IDLE:  if (pix_acc) state_d = rbf_pkg::ST_READ;
      rbf_pkg::ST_READ:  state_d = rbf_pkg::ST_SHIFT;
      rbf_pkg::ST_SHIFT: state_d = emit_q ? rbf_pkg::ST_CALC : rbf_pkg::ST_IDLE;
      rbf_pkg::ST_CALC:  if (calc_last) state_d = rbf_pkg::ST_DRAIN;
      rbf_pkg::ST_DRAIN: if (mac_done) state_d = rbf_pkg::ST_DIV;
      rbf_pkg::ST_DIV:   if (div_done) state_d = rbf_pkg::ST_OUT;
      rbf_pkg::ST_OUT:   if (!out_valid_q || out_ready_i) state_d = rbf_pkg::ST_IDLE;
      default:           state_d = rbf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    line_re    = 1'b0;
    line_we    = 1'b0;
    acc_clr    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    wl         = '0;
    iss        = '0;
    iss.px     = win_q[0];
    iss.sidx   = rbf_pkg::sq_off(a_q) + rbf_pkg::sq_off(b_q);
    iss.last   = calc_last;
    case (state_q)
      rbf_pkg::ST_CLEAR: begin
        wl.rng_we = 1'b1;
        wl.addr   = rbf_pkg::ADDR_W'(clr_q);
      end
      rbf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        wl.addr    = rbf_pkg::ADDR_W'(table_index_i);
        wl.data    = weight_value_i;
        wl.spat_we = in_valid_i && (mode_i == rbf_pkg::MODE_LOAD_SPATIAL) &&
                     (32'(table_index_i) < rbf_pkg::SPATIAL_DEPTH);
        wl.rng_we  = in_valid_i && (mode_i == rbf_pkg::MODE_LOAD_RANGE) &&
                     (32'(table_index_i) < rbf_pkg::RANGE_DEPTH);
      end
      rbf_pkg::ST_READ:  line_re = 1'b1;
      rbf_pkg::ST_SHIFT: begin
        line_we = 1'b1;
        acc_clr = 1'b1;
      end
      rbf_pkg::ST_CALC:  iss.valid = 1'b1;
      rbf_pkg::ST_DRAIN: div_start = mac_done;
      rbf_pkg::ST_OUT:   out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // window: column shift on a new pixel, full rotation while filtering
  always_comb begin
    for (int i = 0; i < rbf_pkg::NWIN; i++) win_d[i] = win_q[i];
    if (state_q == rbf_pkg::ST_SHIFT) begin
      for (int a = 0; a < rbf_pkg::DIAM; a++) begin
        for (int b = 0; b < rbf_pkg::DIAM; b++) begin
          if (b < rbf_pkg::DIAM - 1) win_d[a*rbf_pkg::DIAM+b] = win_q[a*rbf_pkg::DIAM+b+1];
          else if (a < rbf_pkg::LINES) win_d[a*rbf_pkg::DIAM+b] = line_rd[rot_slot(slot_q, a)];
          else win_d[a*rbf_pkg::DIAM+b] = px_q;
        end
      end
    end else if (state_q == rbf_pkg::ST_CALC) begin
      for (int i = 0; i < rbf_pkg::NWIN; i++)
        win_d[i] = win_q[(i == rbf_pkg::NWIN - 1) ? 0 : i + 1];
    end
  end

  for (genvar g = 0; g < rbf_pkg::LINES; g++) begin : g_line
    rbf_ram #(
      .WIDTH(rbf_pkg::PIX_W),
      .DEPTH(rbf_pkg::MAX_WIDTH)
    ) u_line (
      .clk_i  (clk_i),
      .we_i   (line_we && (slot_q == rbf_pkg::LW'(g))),
      .waddr_i(col_q),
      .wdata_i(px_q),
      .re_i   (line_re),
      .raddr_i(col_q),
      .rdata_o(line_rd[g])
    );
  end

  rbf_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wl_i         (wl),
    .iss_i        (iss),
    .centre_i     (centre_q),
    .range_shift_i(range_shift_q),
    .acc_clr_i    (acc_clr),
    .wsum_o       (wsum),
    .csum_o       (csum),
    .done_o       (mac_done)
  );

  rbf_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .wsum_i  (wsum),
    .csum_i  (csum),
    .centre_i(centre_q),
    .chan_o  (chan),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rbf_pkg::ST_CLEAR;
      frame_width_q  <= 11'd1024;
      frame_height_q <= 16'd480;
      range_shift_q  <= 5'd8;
      col_cnt_q      <= '0;
      row_cnt_q      <= '0;
      slot_cnt_q     <= '0;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rbf_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[10:0];
          rbf_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          rbf_pkg::CFG_RANGE_SHIFT:  range_shift_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (state_q == rbf_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (pix_acc) begin
        if (frame_end) begin
          col_cnt_q  <= '0;
          row_cnt_q  <= '0;
          slot_cnt_q <= '0;
        end else if (row_end) begin
          col_cnt_q  <= '0;
          row_cnt_q  <= row_cnt_q + 16'd1;
          slot_cnt_q <= (slot_cnt_q == rbf_pkg::LW'(rbf_pkg::LINES - 1)) ? '0
                                                                       : slot_cnt_q + 1'b1;
        end else begin
          col_cnt_q <= col_cnt_q + 1'b1;
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < rbf_pkg::NWIN; i++) win_q[i] <= win_d[i];
    if (pix_acc) begin
      px_q        <= {red_in_i, green_in_i, blue_in_i};
      col_q       <= col_cnt_q;
      slot_q      <= slot_cnt_q;
      emit_q      <= emit;
      frame_end_q <= frame_end;
    end
    if (state_q == rbf_pkg::ST_SHIFT) begin
      centre_q <= win_d[rbf_pkg::CENTER];
      a_q      <= '0;
      b_q      <= '0;
    end else if (state_q == rbf_pkg::ST_CALC) begin
      if (b_q == rbf_pkg::DW'(rbf_pkg::DIAM - 1)) begin
        b_q <= '0;
        a_q <= a_q + 1'b1;
      end else begin
        b_q <= b_q + 1'b1;
      end
    end
    if (out_load) begin
      out_r_q          <= chan[0];
      out_g_q          <= chan[1];
      out_b_q          <= chan[2];
      out_frame_done_q <= frame_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_r_q;
  assign green_out_o  = out_g_q;
  assign blue_out_o   = out_b_q;
  assign frame_done_o = out_frame_done_q;

endmodule
